>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/crc64bc_pkg.sv
// ----------------------------------------------------------------------------
// crc64bc_pkg
// shared types, constants and the byte fold function of the crc64 checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crc64bc_pkg;

    localparam logic [63:0] CRC_POLY = 64'h42F0_E1EB_A9EA_3693;
    localparam logic [63:0] CRC_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] expected_crc;
        logic        empty_message;
        logic        last_byte;
        logic        first_byte;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [63:0] crc_value;
        logic        crc_match;
    } t_result;

    // lsb-first update, eight shift/xor steps folded into one network
    function automatic logic [63:0] crc_fold_byte(input logic [63:0] crc,
                                                  input logic [7:0]  data);
        logic [63:0] t;
        t = {56'd0, crc[7:0] ^ data};
        for (int k = 0; k < 8; k++) begin
            if (t[0]) begin
                t = (t >> 1) ^ CRC_POLY;
            end else begin
                t = t >> 1;
            end
        end
        return (crc >> 8) ^ t;
    endfunction

endpackage

>>> hdl/crc64bc_in_stage.sv
// ----------------------------------------------------------------------------
// crc64bc_in_stage
// input register with stream handshake and advance control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc64bc_in_stage
    import crc64bc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_out_free,
    output logic     o_adv,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     w_produce;

    // a middle byte needs no output slot
    assign w_produce = r_item.last_byte | r_item.empty_message;
    assign o_adv     = r_valid & (~w_produce | i_out_free);
    assign o_ready   = ~r_valid | o_adv;
    assign o_item    = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> hdl/crc64bc_fold.sv
// ----------------------------------------------------------------------------
// crc64bc_fold
// running crc register and the per-byte update and compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc64bc_fold
    import crc64bc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  t_in_item    i_item,
    output logic        o_produce,
    output t_result     o_result,
    output logic [63:0] o_run_crc
);

    logic [63:0] r_crc;
    logic [63:0] n_crc;
    logic [63:0] w_seed;
    logic [63:0] w_folded;
    logic [63:0] w_final;

    assign w_seed    = i_item.first_byte ? CRC_ONES : r_crc;
    assign w_folded  = crc_fold_byte(w_seed, i_item.data_byte);
    assign w_final   = w_folded ^ CRC_ONES;
    assign o_run_crc = r_crc;

    always_comb begin
        o_produce          = 1'b0;
        o_result.crc_value = w_final;
        o_result.crc_match = (w_final == i_item.expected_crc);
        n_crc              = w_folded;
        if (i_item.empty_message) begin
            o_produce          = 1'b1;
            o_result.crc_value = '0;
            o_result.crc_match = 1'b1;
            n_crc              = CRC_ONES;
        end else if (i_item.last_byte) begin
            // reseed so the next message starts clean
            o_produce = 1'b1;
            n_crc     = CRC_ONES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_ONES;
        end else if (i_adv) begin
            r_crc <= n_crc;
        end
    end

endmodule

>>> hdl/crc64bc_out_stage.sv
// ----------------------------------------------------------------------------
// crc64bc_out_stage
// result register holding one checksum until the sink takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc64bc_out_stage
    import crc64bc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = ~r_valid | i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> hdl/crc64_byte_checksum.sv
// ----------------------------------------------------------------------------
// crc64_byte_checksum
// byte-serial 64-bit crc with a compare against the expected checksum
// path: the last byte waits in the input register, is folded into the running crc,
//   and the result is registered in the result register
// throughput: one byte per cycle unless a closing byte waits on a full result register
// reset: synchronous, active low; clears both valid flags and seeds crc to ones
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module crc64_byte_checksum
    import crc64bc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // data_byte[7:0], expected_crc[71:8]
    input  logic        s_axis_tlast,   // last_byte
    input  logic [1:0]  s_axis_tuser,   // first_byte[0], empty_message[1]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // crc_value[63:0]
    output logic [0:0]  m_axis_tuser    // crc_match[0]
);

    t_in_item    w_in_item;
    t_in_item    w_stage_item;
    t_result     w_fold_result;
    t_result     w_out_result;
    logic        w_adv;
    logic        w_produce;
    logic        w_out_free;
    logic [63:0] w_run_crc;

    // unpack the slave-side transfer into item fields
    assign w_in_item.data_byte     = s_axis_tdata[7:0];
    assign w_in_item.expected_crc  = s_axis_tdata[71:8];
    assign w_in_item.last_byte     = s_axis_tlast;
    assign w_in_item.first_byte    = s_axis_tuser[0];
    assign w_in_item.empty_message = s_axis_tuser[1];

    // input register; advances when the byte has somewhere to go
    crc64bc_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (w_in_item),
        .i_out_free (w_out_free),
        .o_adv      (w_adv),
        .o_item     (w_stage_item)
    );

    // fold network and running crc
    crc64bc_fold u_fold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_item    (w_stage_item),
        .o_produce (w_produce),
        .o_result  (w_fold_result),
        .o_run_crc (w_run_crc)
    );

    // result register parts the sink's stall from the input side
    crc64bc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv & w_produce),
        .i_result (w_fold_result),
        .i_ready  (m_axis_tready),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out_result)
    );

    assign m_axis_tdata    = w_out_result.crc_value;
    assign m_axis_tuser[0] = w_out_result.crc_match;

    // a finished message always lands in the result register
    `ASSERT_CLK(a_result_loads, (w_adv && w_produce) |=> m_axis_tvalid, "result not loaded")

    // running crc is reseeded once a message closes
    `ASSERT_CLK(a_reseed_after_result, (w_adv && w_produce) |=> (w_run_crc == CRC_ONES), "crc not reseeded")

    // empty message reports zero and a match
    `ASSERT_CLK(a_empty_result, (w_adv && w_stage_item.empty_message) |=> (m_axis_tuser[0] && (m_axis_tdata == 64'd0)), "bad empty message result")

    // reset leaves nothing pending and the crc seeded
    `ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (!m_axis_tvalid && (w_run_crc == CRC_ONES)), "reset did not clear")

endmodule
